// ===== rtl/core/crc_pkg.sv =====
`default_nettype none

package crc_pkg;

  // Field widths
  localparam int CNT_W   = 16;           // sensor count
  localparam int RATIO_W = 8;            // saturated ratio
  localparam int DVD_W   = 23;           // count * 100 fits in 23 bits
  localparam int STEP_W  = $clog2(DVD_W);
  localparam int CFG_W   = 8;            // widest register
  localparam int IDX_W   = 3;            // eight registers

  // Register indexes
  localparam logic [IDX_W-1:0] REG_WHITE_LO    = 3'd0;
  localparam logic [IDX_W-1:0] REG_WHITE_HI    = 3'd1;
  localparam logic [IDX_W-1:0] REG_WHITE_GREEN = 3'd2;
  localparam logic [IDX_W-1:0] REG_BLUE_MIN    = 3'd3;
  localparam logic [IDX_W-1:0] REG_GREEN_MAX   = 3'd4;
  localparam logic [IDX_W-1:0] REG_RED_LO      = 3'd5;
  localparam logic [IDX_W-1:0] REG_RED_HI      = 3'd6;
  localparam logic [IDX_W-1:0] REG_RED_GREEN   = 3'd7;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_WHITE_LO    = 8'd105;
  localparam logic [CFG_W-1:0] RST_WHITE_HI    = 8'd140;
  localparam logic [CFG_W-1:0] RST_WHITE_GREEN = 8'd100;
  localparam logic [CFG_W-1:0] RST_BLUE_MIN    = 8'd140;
  localparam logic [CFG_W-1:0] RST_GREEN_MAX   = 8'd90;
  localparam logic [CFG_W-1:0] RST_RED_LO      = 8'd95;
  localparam logic [CFG_W-1:0] RST_RED_HI      = 8'd105;
  localparam logic [CFG_W-1:0] RST_RED_GREEN   = 8'd105;

  // Filter phases
  localparam logic [1:0] PH_CLEAR = 2'd0;
  localparam logic [1:0] PH_BLUE  = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;
  localparam logic [1:0] PH_GREEN = 2'd3;

  // Colour codes
  localparam logic [1:0] COL_RED   = 2'd0;
  localparam logic [1:0] COL_BLUE  = 2'd1;
  localparam logic [1:0] COL_OTHER = 2'd2;

  localparam logic [RATIO_W-1:0] RATIO_MAX = 8'hFF;

  // Request to the shared divider
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  // Divider response: done pulses once, ratio holds until the next start
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [RATIO_W-1:0] ratio;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/color_ratio_classifier.sv =====
// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall  in_sample_count
// out_     output     out_valid/out_stall next selects, decision, colour, four matches
// cfg_     input      cfg_we             cfg_index, cfg_wdata (8 bit registers)
//
// Clear, blue and red counts give their result in the cycle after acceptance.
// The green count runs three 23-step divisions on one restoring divider, each
// through ST_START and ST_WAIT; then ST_EMIT loads the result register when out_free.
// Sync active-low rst_n clears phase, counts bar green, histories; presets registers.
// in_stall is high while a round is computed and while a held result is stalled.
`default_nettype none

module color_ratio_classifier (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [crc_pkg::CNT_W-1:0]   in_sample_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_next_select_s2,
  output logic                             out_next_select_s3,
  output logic                             out_decision_valid,
  output logic [1:0]                       out_color_code,
  output logic                             out_white_match,
  output logic                             out_blue_match,
  output logic                             out_green_match,
  output logic                             out_red_match,
  input  wire logic                        cfg_we,
  input  wire logic [crc_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [crc_pkg::CFG_W-1:0]   cfg_wdata
);
  import crc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // Configuration registers
  logic [CFG_W-1:0] white_lo_r, white_hi_r, white_green_r, blue_min_r;
  logic [CFG_W-1:0] green_max_r, red_lo_r, red_hi_r, red_green_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_lo_r    <= RST_WHITE_LO;
      white_hi_r    <= RST_WHITE_HI;
      white_green_r <= RST_WHITE_GREEN;
      blue_min_r    <= RST_BLUE_MIN;
      green_max_r   <= RST_GREEN_MAX;
      red_lo_r      <= RST_RED_LO;
      red_hi_r      <= RST_RED_HI;
      red_green_r   <= RST_RED_GREEN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHITE_LO:    white_lo_r    <= cfg_wdata;
        REG_WHITE_HI:    white_hi_r    <= cfg_wdata;
        REG_WHITE_GREEN: white_green_r <= cfg_wdata;
        REG_BLUE_MIN:    blue_min_r    <= cfg_wdata;
        REG_GREEN_MAX:   green_max_r   <= cfg_wdata;
        REG_RED_LO:      red_lo_r      <= cfg_wdata;
        REG_RED_HI:      red_hi_r      <= cfg_wdata;
        REG_RED_GREEN:   red_green_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state
  logic [1:0]         state_r;
  logic [1:0]         phase_r;
  logic [1:0]         sel_r;        // 0 blue, 1 red, 2 green ratio
  logic [CNT_W-1:0]   clear_count_r, blue_count_r, red_count_r, green_count_r;
  logic [RATIO_W-1:0] ratio_b_r, ratio_r_r, ratio_g_r;
  logic [3:0]         white_hist_r, blue_hist_r, green_hist_r, red_hist_r;

  // Output register
  logic       out_valid_r;
  logic       out_s2_r, out_s3_r, out_dv_r;
  logic [1:0] out_code_r;
  logic       out_mw_r, out_mb_r, out_mg_r, out_mr_r;

  logic in_acc;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Divider request: selected count times 100 by shift and add
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [CNT_W-1:0] div_count;
  logic [DVD_W-1:0] count_ext;

  always_comb begin
    case (sel_r)
      2'd0:    div_count = blue_count_r;
      2'd1:    div_count = red_count_r;
      default: div_count = green_count_r;
    endcase
  end

  assign count_ext        = DVD_W'(div_count);
  assign div_req.start    = (state_r == ST_START);
  assign div_req.dividend = (count_ext << 6) + (count_ext << 5) + (count_ext << 2);
  assign div_req.divisor  = clear_count_r;

  crc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Threshold matches on the finished ratios
  logic       m_white, m_blue, m_green, m_red;
  logic [3:0] white_hist_nxt, blue_hist_nxt, green_hist_nxt, red_hist_nxt;
  logic [1:0] code_nxt;

  always_comb begin
    m_white = (ratio_r_r > white_lo_r) && (ratio_r_r < white_hi_r) &&
              (ratio_b_r > white_lo_r) && (ratio_b_r < white_hi_r) &&
              (ratio_g_r < white_green_r);
    m_blue  = (ratio_b_r > blue_min_r) && (ratio_r_r > blue_min_r);
    m_green = (ratio_r_r < green_max_r) && (ratio_b_r < green_max_r);
    m_red   = (ratio_r_r > red_lo_r) && (ratio_r_r < red_hi_r) &&
              (ratio_b_r > red_lo_r) && (ratio_b_r < red_hi_r) &&
              (ratio_g_r < red_green_r);
    white_hist_nxt = {white_hist_r[2:0], m_white};
    blue_hist_nxt  = {blue_hist_r[2:0], m_blue};
    green_hist_nxt = {green_hist_r[2:0], m_green};
    red_hist_nxt   = {red_hist_r[2:0], m_red};
    if (&red_hist_nxt)       code_nxt = COL_RED;
    else if (&blue_hist_nxt) code_nxt = COL_BLUE;
    else                     code_nxt = COL_OTHER;
  end

  // Sequencer and round state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= PH_CLEAR;
      sel_r         <= 2'd0;
      clear_count_r <= '0;
      blue_count_r  <= '0;
      red_count_r   <= '0;
      white_hist_r  <= '0;
      blue_hist_r   <= '0;
      green_hist_r  <= '0;
      red_hist_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            phase_r <= phase_r + 2'd1;
            case (phase_r)
              PH_CLEAR: clear_count_r <= in_sample_count;
              PH_BLUE:  blue_count_r  <= in_sample_count;
              PH_RED:   red_count_r   <= in_sample_count;
              default: begin
                green_count_r <= in_sample_count;
                sel_r         <= 2'd0;
                state_r       <= ST_START;
              end
            endcase
          end
        end
        ST_START: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (div_rsp.done) begin
            case (sel_r)
              2'd0:    ratio_b_r <= div_rsp.ratio;
              2'd1:    ratio_r_r <= div_rsp.ratio;
              default: ratio_g_r <= div_rsp.ratio;
            endcase
            sel_r   <= sel_r + 2'd1;
            state_r <= (sel_r == 2'd2) ? ST_EMIT : ST_START;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            white_hist_r <= white_hist_nxt;
            blue_hist_r  <= blue_hist_nxt;
            green_hist_r <= green_hist_nxt;
            red_hist_r   <= red_hist_nxt;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result register
  logic [1:0] ph_next;
  assign ph_next = phase_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && phase_r != PH_GREEN) begin
      out_valid_r <= 1'b1;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && phase_r != PH_GREEN) begin
      out_s2_r   <= (ph_next == PH_GREEN);
      out_s3_r   <= (ph_next == PH_BLUE) || (ph_next == PH_GREEN);
      out_dv_r   <= 1'b0;
      out_code_r <= COL_RED;
      out_mw_r   <= 1'b0;
      out_mb_r   <= 1'b0;
      out_mg_r   <= 1'b0;
      out_mr_r   <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      // next filter after green is clear
      out_s2_r   <= 1'b1;
      out_s3_r   <= 1'b0;
      out_dv_r   <= 1'b1;
      out_code_r <= code_nxt;
      out_mw_r   <= m_white;
      out_mb_r   <= m_blue;
      out_mg_r   <= m_green;
      out_mr_r   <= m_red;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_select_s2 = out_s2_r;
  assign out_next_select_s3 = out_s3_r;
  assign out_decision_valid = out_dv_r;
  assign out_color_code     = out_code_r;
  assign out_white_match    = out_mw_r;
  assign out_blue_match     = out_mb_r;
  assign out_green_match    = out_mg_r;
  assign out_red_match      = out_mr_r;

  // Checks
  a_decision_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dv_r |-> out_s2_r && !out_s3_r)
    else $error("decision word without a wrap to the clear filter");

  a_green_starts_round: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_GREEN |=> state_r == ST_START && phase_r == PH_CLEAR)
    else $error("green count did not start the ratio round");

  a_div_idle_outside_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_code_r != 2'd3)
    else $error("colour code out of range");

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && out_free |=> state_r == ST_IDLE && out_valid_r && out_dv_r)
    else $error("round result not loaded");

endmodule

`default_nettype wire

// ===== rtl/core/crc_div.sv =====
`default_nettype none

module crc_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire crc_pkg::div_req_t req,
  output crc_pkg::div_rsp_t     rsp
);
  import crc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dsr_r;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // One restoring step: bring down the next dividend bit, try the subtract.
  // A zero divisor always fits, so the quotient comes out all ones and saturates.
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  // Saturate anything above eight bits
  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.ratio = (|quo_r[DVD_W-1:RATIO_W]) ? RATIO_MAX : quo_r[RATIO_W-1:0];

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
  import crc_pkg::*;

  // One result word as seen on the out_ channel
  typedef struct packed {
    logic       s2;
    logic       s3;
    logic       decided;
    logic [1:0] colour;
    logic       white;
    logic       blue;
    logic       green;
    logic       red;
  } sensor_word_t;

  typedef enum int {AIM_RED, AIM_BLUE, AIM_WHITE, AIM_GREEN, AIM_NOISE, AIM_EDGE} aim_t;
  typedef enum int {THR_DEFAULT, THR_ZERO, THR_FULL, THR_WIDE, THR_RANDOM} thr_set_t;

  // Threshold setting per random phase; the last one runs without idling
  localparam thr_set_t PHASE_PLAN [6] = '{THR_RANDOM, THR_ZERO, THR_FULL, THR_WIDE,
                                          THR_RANDOM, THR_DEFAULT};
  localparam int ROUND_WORDS_PER_PHASE = 204;

  // Directed rounds: clear, blue, red, green counts
  localparam logic [CNT_W-1:0] DIRECTED [24] = '{
    // count extremes, ratios of 100 and 0: red match
    16'd65535, 16'd65535, 16'd65535, 16'd0,
    // nominal red
    16'd1000, 16'd1000, 16'd1000, 16'd500,
    // zero clear count, every ratio saturates
    16'd0, 16'd1234, 16'd0, 16'd65535,
    // tiny clear count, blue and red quotients well above 255
    16'd1, 16'd65535, 16'd300, 16'd2,
    // white
    16'd1000, 16'd1200, 16'd1200, 16'd500,
    // green
    16'd1000, 16'd500, 16'd500, 16'd500
  };

  // Colour round predictor and store of expected result words
  class colour_scoreboard;
    logic [CFG_W-1:0] thr [8];
    logic [1:0]       phase;
    logic [CNT_W-1:0] clear_cnt, blue_cnt, red_cnt;
    logic [3:0]       white_hist, blue_hist, green_hist, red_hist;
    sensor_word_t     expected_words [$];
    int               failures;

    function new();
      thr[REG_WHITE_LO]    = RST_WHITE_LO;
      thr[REG_WHITE_HI]    = RST_WHITE_HI;
      thr[REG_WHITE_GREEN] = RST_WHITE_GREEN;
      thr[REG_BLUE_MIN]    = RST_BLUE_MIN;
      thr[REG_GREEN_MAX]   = RST_GREEN_MAX;
      thr[REG_RED_LO]      = RST_RED_LO;
      thr[REG_RED_HI]      = RST_RED_HI;
      thr[REG_RED_GREEN]   = RST_RED_GREEN;
      phase      = PH_CLEAR;
      clear_cnt  = '0;
      blue_cnt   = '0;
      red_cnt    = '0;
      white_hist = '0;
      blue_hist  = '0;
      green_hist = '0;
      red_hist   = '0;
      failures   = 0;
    endfunction

    // count * 100 / base, saturating at 255; zero base saturates too
    function logic [RATIO_W-1:0] ratio(logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] base);
      int unsigned q;
      if (base == '0) return RATIO_MAX;
      q = (32'(cnt) * 32'd100) / 32'(base);
      return (q > 32'd255) ? RATIO_MAX : RATIO_W'(q);
    endfunction

    // Accepted input word: advance the round and queue the result it causes
    function void note_word(logic [CNT_W-1:0] cnt);
      sensor_word_t w;
      logic [RATIO_W-1:0] rb, rr, rg;
      logic [1:0] nxt;
      w = '0;
      case (phase)
        PH_CLEAR: clear_cnt = cnt;
        PH_BLUE:  blue_cnt  = cnt;
        PH_RED:   red_cnt   = cnt;
        default: begin
          // green count completes the round
          rb = ratio(blue_cnt, clear_cnt);
          rr = ratio(red_cnt, clear_cnt);
          rg = ratio(cnt, clear_cnt);
          w.white = rr > thr[REG_WHITE_LO] && rr < thr[REG_WHITE_HI] &&
                    rb > thr[REG_WHITE_LO] && rb < thr[REG_WHITE_HI] &&
                    rg < thr[REG_WHITE_GREEN];
          w.blue  = rb > thr[REG_BLUE_MIN] && rr > thr[REG_BLUE_MIN];
          w.green = rr < thr[REG_GREEN_MAX] && rb < thr[REG_GREEN_MAX];
          w.red   = rr > thr[REG_RED_LO] && rr < thr[REG_RED_HI] &&
                    rb > thr[REG_RED_LO] && rb < thr[REG_RED_HI] &&
                    rg < thr[REG_RED_GREEN];
          white_hist = {white_hist[2:0], w.white};
          blue_hist  = {blue_hist[2:0], w.blue};
          green_hist = {green_hist[2:0], w.green};
          red_hist   = {red_hist[2:0], w.red};
          // red wins over blue; anything else is other
          if (&red_hist)       w.colour = COL_RED;
          else if (&blue_hist) w.colour = COL_BLUE;
          else                 w.colour = COL_OTHER;
          w.decided = 1'b1;
        end
      endcase
      nxt   = phase + 2'd1;
      phase = nxt;
      w.s2  = (nxt == PH_CLEAR) || (nxt == PH_GREEN);
      w.s3  = (nxt == PH_BLUE) || (nxt == PH_GREEN);
      expected_words.push_back(w);
    endfunction

    function void compare_field(string name, logic [1:0] want, logic [1:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, seen);
        failures++;
      end
    endfunction

    // Accepted result word: compare with the oldest expectation
    function void check_word(sensor_word_t got);
      sensor_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word %h with nothing expected", got);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("next_select_s2", 2'(want.s2), 2'(got.s2));
      compare_field("next_select_s3", 2'(want.s3), 2'(got.s3));
      compare_field("decision_valid", 2'(want.decided), 2'(got.decided));
      compare_field("color_code", want.colour, got.colour);
      compare_field("white_match", 2'(want.white), 2'(got.white));
      compare_field("blue_match", 2'(want.blue), 2'(got.blue));
      compare_field("green_match", 2'(want.green), 2'(got.green));
      compare_field("red_match", 2'(want.red), 2'(got.red));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CNT_W-1:0] in_sample_count = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_next_select_s2;
  logic             out_next_select_s3;
  logic             out_decision_valid;
  logic [1:0]       out_color_code;
  logic             out_white_match;
  logic             out_blue_match;
  logic             out_green_match;
  logic             out_red_match;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  colour_scoreboard board;
  bit quiet = 1'b0;         // no idling on either side
  bit send_idling = 1'b0;
  bit hold_request = 1'b0;  // ask the receiver for one long hold-off

  always #6 clk = ~clk;

  color_ratio_classifier uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_count    (in_sample_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_next_select_s2 (out_next_select_s2),
    .out_next_select_s3 (out_next_select_s3),
    .out_decision_valid (out_decision_valid),
    .out_color_code     (out_color_code),
    .out_white_match    (out_white_match),
    .out_blue_match     (out_blue_match),
    .out_green_match    (out_green_match),
    .out_red_match      (out_red_match),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Ratio strictly inside (lo, hi); any ratio if the window is empty
  function automatic int pick_between(int lo, int hi);
    return (hi - lo >= 2) ? $urandom_range(lo + 1, hi - 1) : $urandom_range(0, 255);
  endfunction

  function automatic int pick_below(int limit);
    return (limit > 0) ? $urandom_range(0, limit - 1) : $urandom_range(0, 255);
  endfunction

  function automatic int pick_above(int limit);
    return (limit < 255) ? $urandom_range(limit + 1, 255) : 255;
  endfunction

  // Smallest count whose ratio to base is exactly the target (base >= 100)
  function automatic logic [CNT_W-1:0] scaled_count(int target, int base);
    return CNT_W'((target * base + 99) / 100);
  endfunction

  // Offer one word, with an optional idle burst first
  task automatic send_word(logic [CNT_W-1:0] cnt);
    if (!quiet && send_idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_count <= cnt;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_word(cnt);
  endtask

  // One four-filter round aimed at a class under the current thresholds
  task automatic send_round(aim_t aim);
    logic [CNT_W-1:0] counts [4];
    int base, rb, rr, rg;
    base = $urandom_range(100, 25000);
    rb   = $urandom_range(0, 255);
    rr   = $urandom_range(0, 255);
    rg   = $urandom_range(0, 255);
    case (aim)
      AIM_RED: begin
        rb = pick_between(int'(board.thr[REG_RED_LO]), int'(board.thr[REG_RED_HI]));
        rr = pick_between(int'(board.thr[REG_RED_LO]), int'(board.thr[REG_RED_HI]));
        rg = pick_below(int'(board.thr[REG_RED_GREEN]));
      end
      AIM_WHITE: begin
        rb = pick_between(int'(board.thr[REG_WHITE_LO]), int'(board.thr[REG_WHITE_HI]));
        rr = pick_between(int'(board.thr[REG_WHITE_LO]), int'(board.thr[REG_WHITE_HI]));
        rg = pick_below(int'(board.thr[REG_WHITE_GREEN]));
      end
      AIM_BLUE: begin
        rb = pick_above(int'(board.thr[REG_BLUE_MIN]));
        rr = pick_above(int'(board.thr[REG_BLUE_MIN]));
      end
      AIM_GREEN: begin
        rb = pick_below(int'(board.thr[REG_GREEN_MAX]));
        rr = pick_below(int'(board.thr[REG_GREEN_MAX]));
      end
      default: ;
    endcase
    counts[0] = CNT_W'(base);
    counts[1] = scaled_count(rb, base);
    counts[2] = scaled_count(rr, base);
    counts[3] = scaled_count(rg, base);
    // noise and edge rounds ignore the targets
    if (aim == AIM_NOISE) begin
      foreach (counts[i]) counts[i] = CNT_W'($urandom_range(0, 65535));
    end else if (aim == AIM_EDGE) begin
      foreach (counts[i]) begin
        case ($urandom_range(0, 5))
          0:       counts[i] = '0;
          1:       counts[i] = 16'd1;
          2:       counts[i] = '1;
          3:       counts[i] = 16'd100;
          4:       counts[i] = 16'd65534;
          default: counts[i] = CNT_W'($urandom_range(0, 65535));
        endcase
      end
    end
    foreach (counts[i]) send_word(counts[i]);
  endtask

  // Write all eight thresholds; only called while the block is idle
  task automatic load_thresholds(thr_set_t choice);
    logic [CFG_W-1:0] vals [8];
    int lo;
    foreach (vals[i]) vals[i] = '0;
    case (choice)
      THR_DEFAULT: begin
        vals[REG_WHITE_LO]    = RST_WHITE_LO;
        vals[REG_WHITE_HI]    = RST_WHITE_HI;
        vals[REG_WHITE_GREEN] = RST_WHITE_GREEN;
        vals[REG_BLUE_MIN]    = RST_BLUE_MIN;
        vals[REG_GREEN_MAX]   = RST_GREEN_MAX;
        vals[REG_RED_LO]      = RST_RED_LO;
        vals[REG_RED_HI]      = RST_RED_HI;
        vals[REG_RED_GREEN]   = RST_RED_GREEN;
      end
      THR_ZERO: ;
      THR_FULL: foreach (vals[i]) vals[i] = '1;
      THR_WIDE: begin
        vals[REG_WHITE_HI]    = '1;
        vals[REG_WHITE_GREEN] = '1;
        vals[REG_GREEN_MAX]   = '1;
        vals[REG_RED_HI]      = '1;
        vals[REG_RED_GREEN]   = '1;
      end
      default: begin
        lo = $urandom_range(0, 200);
        vals[REG_WHITE_LO]    = CFG_W'(lo);
        vals[REG_WHITE_HI]    = CFG_W'(lo + $urandom_range(2, 55));
        lo = $urandom_range(0, 200);
        vals[REG_RED_LO]      = CFG_W'(lo);
        vals[REG_RED_HI]      = CFG_W'(lo + $urandom_range(2, 55));
        vals[REG_WHITE_GREEN] = CFG_W'($urandom_range(0, 255));
        vals[REG_RED_GREEN]   = CFG_W'($urandom_range(0, 255));
        vals[REG_BLUE_MIN]    = CFG_W'($urandom_range(0, 255));
        vals[REG_GREEN_MAX]   = CFG_W'($urandom_range(0, 255));
      end
    endcase
    foreach (vals[i]) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_wdata <= vals[i];
      board.thr[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: check accepted words, stall in bursts, one long hold-off
  initial begin
    sensor_word_t got;
    int hold_left;
    bit bursty;
    hold_left = 0;
    bursty    = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        got = {out_next_select_s2, out_next_select_s3, out_decision_valid, out_color_code,
               out_white_match, out_blue_match, out_green_match, out_red_match};
        board.check_word(got);
      end
      if ($urandom_range(0, 63) == 0) bursty = !bursty;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) out_stall <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        out_stall   <= 1'b1;
        hold_left    = 300;
      end else if (!quiet && bursty && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        hold_left  = $urandom_range(1, 15);
      end
    end
  end

  // Stimulus: directed rounds, then random rounds under several threshold sets
  initial begin
    aim_t aim;
    int run_len;
    int sent;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idling = 1'b1;
    foreach (DIRECTED[i]) send_word(DIRECTED[i]);
    in_valid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      load_thresholds(PHASE_PLAN[ph]);
      quiet = (ph == 5);
      if (ph == 0) hold_request = 1'b1;
      sent = 0;
      // runs of rounds of one kind, so that the histories fill up
      while (sent < ROUND_WORDS_PER_PHASE) begin
        aim         = aim_t'($urandom_range(0, 5));
        run_len     = $urandom_range(1, 6);
        send_idling = ($urandom_range(0, 2) != 0);
        repeat (run_len) begin
          send_round(aim);
          sent += 4;
        end
      end
      in_valid <= 1'b0;
      while (board.expected_words.size() != 0) @(posedge clk);
    end

    // allow for a stray word after the last round
    repeat (120) @(posedge clk);
    if (board.failures == 0 && board.expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
